FILE: hdl/pswrl_pkg.sv
package pswrl_pkg;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] source_id;
        logic [47:0] time_ms;
        logic [4:0]  local_hour;
        logic [4:0]  hour_before;
        logic [3:0]  object_class;
    } req_t;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [3:0]  class_index;
        logic [15:0] class_count;
        logic [19:0] digest_total;
        logic        last;
    } rsp_t;

    localparam logic [1:0] RQ_EVENT  = 2'd0;
    localparam logic [1:0] RQ_OBJECT = 2'd1;
    localparam logic [1:0] RQ_DIGEST = 2'd2;
    localparam logic [1:0] RQ_NONE   = 2'd3;

    localparam logic [2:0] OC_PASS   = 3'd0;
    localparam logic [2:0] OC_SILENT = 3'd1;
    localparam logic [2:0] OC_BUDGET = 3'd2;
    localparam logic [2:0] OC_FULL   = 3'd3;
    localparam logic [2:0] OC_DIGEST = 3'd4;

    localparam logic [1:0] CFG_BUDGET    = 2'd0;
    localparam logic [1:0] CFG_SIL_START = 2'd1;
    localparam logic [1:0] CFG_SIL_END   = 2'd2;

    localparam logic [47:0] HOUR_MS        = 48'd3600000;
    localparam logic [7:0]  DEFAULT_BUDGET = 8'd6;
    localparam logic [4:0]  MAX_OUT        = 5'd16;
    localparam logic [19:0] TOTAL_MAX      = 20'hFFFFF;
    localparam logic [15:0] CNT_MAX        = 16'hFFFF;

    typedef struct packed {
        logic       latch;
        logic       scan_clr;
        logic       scan_rd;
        logic       scan_inc;
        logic       alloc;
        logic       load_rd;
        logic       elap_cap;
        logic       win_reset;
        logic       cls_clr;
        logic       cls_inc;
        logic       addr_cls;
        logic       cnt_rd;
        logic       cnt_wr;
        logic       wr_bump;
        logic       sum_clr;
        logic       sum_acc;
        logic       n_clr;
        logic       emit_out;
        logic       pass_wr;
        logic       out_load;
        logic [2:0] out_code;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       scan_end;
        logic       tag_hit;
        logic       full;
        logic       cls_last;
        logic       cls_ok;
        logic       elapsed;
        logic       elapsed_hold;
        logic       silent_now;
        logic       silent_prev;
        logic       budget_hit;
        logic       any_nz;
        logic       cnt_nz;
        logic       emit_room;
        logic       out_free;
    } sts_t;

    function automatic logic is_silent(input logic [5:0] s, input logic [5:0] e,
                                       input logic [4:0] h);
        logic signed [6:0] hs;
        logic signed [6:0] ss;
        logic signed [6:0] es;
        logic              r;
        hs = {2'b00, h};
        ss = {s[5], s};
        es = {e[5], e};
        if (ss < 0 || es < 0 || ss == es)
            r = 1'b0;
        else if (ss < es)
            r = (hs >= ss) && (hs < es);
        else
            r = (hs >= ss) || (hs < es);
        return r;
    endfunction

endpackage

FILE: hdl/pswrl_ctrl.sv
module pswrl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pswrl_pkg::sts_t  sts,
    output pswrl_pkg::cmd_t  cmd
);
    import pswrl_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CMP = 4'd2;
    localparam logic [3:0] S_MISS     = 4'd3;
    localparam logic [3:0] S_FULL     = 4'd4;
    localparam logic [3:0] S_CHECK    = 4'd5;
    localparam logic [3:0] S_CLEAR    = 4'd6;
    localparam logic [3:0] S_DECIDE   = 4'd7;
    localparam logic [3:0] S_BUMP_RD  = 4'd8;
    localparam logic [3:0] S_BUMP_WR  = 4'd9;
    localparam logic [3:0] S_SUM_RD   = 4'd10;
    localparam logic [3:0] S_SUM_ACC  = 4'd11;
    localparam logic [3:0] S_SUM_DONE = 4'd12;
    localparam logic [3:0] S_EMIT_RD  = 4'd13;
    localparam logic [3:0] S_EMIT     = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch    = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (sts.req_type == RQ_NONE)
                    state_next = S_IDLE;
                else if (sts.scan_end)
                    state_next = S_MISS;
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (sts.tag_hit)
                begin
                    if (sts.req_type == RQ_OBJECT)
                        state_next = S_BUMP_RD;
                    else
                    begin
                        cmd.load_rd = 1'b1;
                        state_next  = S_CHECK;
                    end
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_MISS:
            begin
                if (sts.req_type == RQ_DIGEST)
                    state_next = S_IDLE;
                else if (sts.full)
                    state_next = S_FULL;
                else
                begin
                    cmd.alloc   = 1'b1;
                    cmd.cls_clr = 1'b1;
                    state_next  = S_CLEAR;
                end
            end
            S_FULL:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_code = OC_FULL;
                    state_next   = S_IDLE;
                end
            end
            S_CHECK:
            begin
                if (sts.req_type == RQ_DIGEST)
                begin
                    cmd.elap_cap = 1'b1;
                    cmd.cls_clr  = 1'b1;
                    cmd.sum_clr  = 1'b1;
                    state_next   = S_SUM_RD;
                end
                else if (sts.elapsed)
                begin
                    cmd.win_reset = 1'b1;
                    cmd.cls_clr   = 1'b1;
                    state_next    = S_CLEAR;
                end
                else
                    state_next = S_DECIDE;
            end
            S_CLEAR:
            begin
                cmd.cnt_wr = 1'b1;
                if (sts.cls_last)
                    state_next = (sts.req_type == RQ_EVENT) ? S_DECIDE : S_BUMP_RD;
                else
                    cmd.cls_inc = 1'b1;
            end
            S_DECIDE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.silent_now)
                        cmd.out_code = OC_SILENT;
                    else if (sts.budget_hit)
                        cmd.out_code = OC_BUDGET;
                    else
                    begin
                        cmd.out_code = OC_PASS;
                        cmd.pass_wr  = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_BUMP_RD:
            begin
                if (!sts.cls_ok)
                    state_next = S_IDLE;
                else
                begin
                    cmd.cnt_rd   = 1'b1;
                    cmd.addr_cls = 1'b1;
                    state_next   = S_BUMP_WR;
                end
            end
            S_BUMP_WR:
            begin
                cmd.cnt_wr   = 1'b1;
                cmd.wr_bump  = 1'b1;
                cmd.addr_cls = 1'b1;
                state_next   = S_IDLE;
            end
            S_SUM_RD:
            begin
                cmd.cnt_rd = 1'b1;
                state_next = S_SUM_ACC;
            end
            S_SUM_ACC:
            begin
                cmd.sum_acc = 1'b1;
                if (sts.cls_last)
                    state_next = S_SUM_DONE;
                else
                begin
                    cmd.cls_inc = 1'b1;
                    state_next  = S_SUM_RD;
                end
            end
            S_SUM_DONE:
            begin
                if (sts.any_nz &&
                    ((!sts.silent_now && sts.silent_prev) || sts.elapsed_hold))
                begin
                    cmd.cls_clr = 1'b1;
                    cmd.n_clr   = 1'b1;
                    state_next  = S_EMIT_RD;
                end
                else
                    state_next = S_IDLE;
            end
            S_EMIT_RD:
            begin
                cmd.cnt_rd = 1'b1;
                cmd.cnt_wr = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!(sts.cnt_nz && sts.emit_room) || sts.out_free)
                begin
                    cmd.emit_out = sts.cnt_nz && sts.emit_room;
                    if (sts.cls_last)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.cls_inc = 1'b1;
                        state_next  = S_EMIT_RD;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

FILE: hdl/pswrl_dpath.sv
module pswrl_dpath #(
    parameter int SOURCES = 64,
    parameter int CLASSES = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pswrl_pkg::cmd_t  cmd,
    output pswrl_pkg::sts_t  sts,
    input  pswrl_pkg::req_t  in_item,
    input  logic             cfg_valid,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data,
    output logic             out_valid,
    input  logic             out_ready,
    output pswrl_pkg::rsp_t  out_item
);
    import pswrl_pkg::*;

    localparam int IW    = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int FW    = $clog2(SOURCES + 1);
    localparam int CW    = (CLASSES > 1) ? $clog2(CLASSES) : 1;
    localparam int NW    = $clog2(CLASSES + 1);
    localparam int DEPTH = SOURCES * CLASSES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0] tag_mem  [SOURCES];
    logic [47:0] win_mem  [SOURCES];
    logic [7:0]  pass_mem [SOURCES];
    logic [15:0] cnt_mem  [DEPTH];

    req_t        req_reg;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] scan_reg;
    logic [CW-1:0] cls_reg;
    logic [31:0] tag_q;
    logic [47:0] win_q;
    logic [7:0]  pass_q;
    logic [15:0] cnt_q;
    logic        elapsed_reg;
    logic [19:0] total_reg;
    logic [NW-1:0] nz_reg;
    logic [4:0]  n_reg;
    logic [7:0]  budget_reg;
    logic [5:0]  sil_start_reg;
    logic [5:0]  sil_end_reg;
    logic        out_valid_reg;
    rsp_t        out_item_reg;

    logic [IW-1:0] slot_idx;
    logic [AW-1:0] cnt_addr;
    logic [15:0]   cnt_wdata;
    logic [20:0]   sum;
    logic [7:0]    budget_eff;
    logic [6:0]    nz_ext;
    logic [4:0]    emit_n;
    logic          elapsed;
    logic          last_entry;

    assign slot_idx  = scan_reg[IW-1:0];
    assign cnt_addr  = AW'(slot_idx) * AW'(CLASSES)
                     + (cmd.addr_cls ? AW'(req_reg.object_class) : AW'(cls_reg));
    assign cnt_wdata = !cmd.wr_bump ? 16'd0 : (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 16'd1;
    assign sum       = {1'b0, total_reg} + 21'(cnt_q);
    assign budget_eff = (budget_reg == 8'd0) ? DEFAULT_BUDGET : budget_reg;
    assign nz_ext    = 7'(nz_reg);
    assign emit_n    = (nz_ext >= 7'd16) ? MAX_OUT : 5'(nz_ext);
    assign elapsed   = (req_reg.time_ms >= win_q) && ((req_reg.time_ms - win_q) >= HOUR_MS);
    assign last_entry = (n_reg == emit_n - 5'd1);

    always_comb
    begin
        sts.req_type     = req_reg.req_type;
        sts.scan_end     = (scan_reg == fill_reg);
        sts.tag_hit      = (tag_q == req_reg.source_id);
        sts.full         = (fill_reg == FW'(SOURCES));
        sts.cls_last     = (cls_reg == CW'(CLASSES - 1));
        sts.cls_ok       = (int'(req_reg.object_class) < CLASSES);
        sts.elapsed      = elapsed;
        sts.elapsed_hold = elapsed_reg;
        sts.silent_now   = is_silent(sil_start_reg, sil_end_reg, req_reg.local_hour);
        sts.silent_prev  = is_silent(sil_start_reg, sil_end_reg, req_reg.hour_before);
        sts.budget_hit   = (pass_q >= budget_eff);
        sts.any_nz       = (nz_reg != '0);
        sts.cnt_nz       = (cnt_q != 16'd0);
        sts.emit_room    = (n_reg < emit_n);
        sts.out_free     = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd)
            tag_q <= tag_mem[slot_idx];
        if (cmd.alloc)
            tag_mem[slot_idx] <= req_reg.source_id;
        if (cmd.alloc || cmd.win_reset)
        begin
            win_mem[slot_idx]  <= req_reg.time_ms;
            pass_mem[slot_idx] <= 8'd0;
        end
        else if (cmd.pass_wr)
            pass_mem[slot_idx] <= pass_q + 8'd1;
        if (cmd.load_rd)
        begin
            win_q  <= win_mem[slot_idx];
            pass_q <= pass_mem[slot_idx];
        end
        else if (cmd.alloc || cmd.win_reset)
            pass_q <= 8'd0;
        if (cmd.cnt_rd)
            cnt_q <= cnt_mem[cnt_addr];
        if (cmd.cnt_wr)
            cnt_mem[cnt_addr] <= cnt_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            req_reg <= in_item;
        if (cmd.scan_clr)
            scan_reg <= '0;
        else if (cmd.scan_inc)
            scan_reg <= scan_reg + FW'(1);
        if (cmd.cls_clr)
            cls_reg <= '0;
        else if (cmd.cls_inc)
            cls_reg <= cls_reg + CW'(1);
        if (cmd.elap_cap)
            elapsed_reg <= elapsed;
        if (cmd.sum_clr)
        begin
            total_reg <= 20'd0;
            nz_reg    <= '0;
        end
        else if (cmd.sum_acc && cnt_q != 16'd0)
        begin
            total_reg <= (sum > 21'(TOTAL_MAX)) ? TOTAL_MAX : sum[19:0];
            nz_reg    <= nz_reg + NW'(1);
        end
        if (cmd.n_clr)
            n_reg <= 5'd0;
        else if (cmd.emit_out)
            n_reg <= n_reg + 5'd1;
        if (cmd.out_load)
        begin
            out_item_reg.outcome      <= cmd.out_code;
            out_item_reg.class_index  <= 4'd0;
            out_item_reg.class_count  <= 16'd0;
            out_item_reg.digest_total <= 20'd0;
            out_item_reg.last         <= 1'b1;
        end
        else if (cmd.emit_out)
        begin
            out_item_reg.outcome      <= OC_DIGEST;
            out_item_reg.class_index  <= 4'(cls_reg);
            out_item_reg.class_count  <= cnt_q;
            out_item_reg.digest_total <= total_reg;
            out_item_reg.last         <= last_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            budget_reg    <= DEFAULT_BUDGET;
            sil_start_reg <= 6'h3F;
            sil_end_reg   <= 6'h3F;
        end
        else
        begin
            if (cmd.alloc)
                fill_reg <= fill_reg + FW'(1);
            if (cmd.out_load || cmd.emit_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_BUDGET:    budget_reg    <= cfg_data;
                    CFG_SIL_START: sil_start_reg <= cfg_data[5:0];
                    CFG_SIL_END:   sil_end_reg   <= cfg_data[5:0];
                    default:       ;
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: hdl/per_source_window_rate_limiter_unit.sv
// Per-source one-hour window rate limiter with suppressed-object digests.
// Input items arrive on in_valid/in_ready with an in_item struct; results
// leave on out_valid/out_ready as out_item structs, one output register deep.
// Registers are written on cfg_valid/cfg_ready (always ready) by cfg_index.
// One item is worked at a time. The source lookup walks the slot table one
// stored slot at a time through the single tag memory read port, reading
// and then comparing each slot before the item's work starts. A new slot or
// a restarted window clears its class counters at one per cycle. A digest
// sums the counters, then reads them again to emit and clear them when it
// has a digest to send, giving up to sixteen results.
// in_ready is high only between items; a finished result may still sit in the
// output register while the next item is taken. A stalled receiver holds the
// block in its current output step until the register frees.
// Reset empties the slot table through its fill count and restores budget 6
// with silent hours disabled; no memory clearing pass is needed.
module per_source_window_rate_limiter_unit #(
    parameter int SOURCES = 64,
    parameter int CLASSES = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pswrl_pkg::req_t  in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output pswrl_pkg::rsp_t  out_item,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data
);
    import pswrl_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    pswrl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pswrl_dpath #(
        .SOURCES (SOURCES),
        .CLASSES (CLASSES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
